// File: sv/mf3_pkg.sv
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CNT_W      = $clog2(MAX_WIDTH);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0]       col_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_W-1:0] size_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    pix_t median;
    logic line_end;
    logic frame_end;
  } result_t;

  typedef struct packed {
    logic last_col;
    logic last_row;
    logic emit;
  } tag_t;

  // Last valid position for a configured size, with out-of-range sizes clamped.
  function automatic cnt_t last_pos(size_t v, int unsigned limit);
    cnt_t r;
    if (v < size_t'(3)) begin
      r = cnt_t'(2);
    end else if (v > size_t'(limit)) begin
      r = cnt_t'(limit - 1);
    end else begin
      r = cnt_t'(v - size_t'(1));
    end
    return r;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Ascending: element 0 is the smallest.
  function automatic col_t sort3(col_t c);
    col_t s;
    s[0] = min3(c[0], c[1], c[2]);
    s[1] = med3(c[0], c[1], c[2]);
    s[2] = max3(c[0], c[1], c[2]);
    return s;
  endfunction

endpackage

// File: sv/mf3_ifs.sv
interface mf3_in_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf3_out_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  pix_t median;
  logic line_end;
  logic frame_end;
  modport source (output valid, output median, output line_end, output frame_end, input ready);
  modport sink   (input valid, input median, input line_end, input frame_end, output ready);
endinterface

interface mf3_cfg_if;
  import mf3_pkg::*;
  logic     valid;
  logic     ready;
  reg_idx_t index;
  size_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mf3_cell.sv
module mf3_cell (
  input  logic          clk,
  input  logic          en,
  input  mf3_pkg::col_t col_in,
  output mf3_pkg::col_t col_q
);
  import mf3_pkg::*;

  col_t col_r;

  // Each cell keeps one window column in sorted order and passes it on
  // to its neighbor when the next word moves through.
  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= sort3(col_in);
    end
  end

  assign col_q = col_r;

endmodule

// File: sv/mf3_fifo.sv
module mf3_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mf3_pkg::result_t push_data,
  input  logic             pop,
  output logic             valid,
  output mf3_pkg::result_t data
);
  import mf3_pkg::*;

  result_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r;
  logic [FIFO_AW-1:0]     rd_ptr_r;
  logic [FIFO_AW:0]       count_r;
  logic                   do_pop;

  assign valid  = (count_r != '0);
  assign data   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
    end
  end

endmodule

// File: sv/median_filter_3x3_top.sv
// 3x3 median filter for 8-bit grey pixels in raster order. One pixel word is
// taken per clock, sustained, as long as the 8-word result queue has room;
// each result passes the input registers, the column cells, the lo/mid/hi
// registers and the result queue. A result is given only when the window
// is complete (column >= 2 and row >= 2) and is the median of the
// neighborhood of the pixel one row up and one column left; line_end and
// frame_end mark the last result of a row and of a frame. The rate is set
// by the two 4096 x 8 line stores, each read once and written once per
// pixel, and by a row of three column cells feeding a registered
// median-of-nine network. The user must write frame_width and frame_height
// on the cfg port only while no pixels are in flight; the block does not
// enforce this. Values outside 3..4096 are clamped. The line stores are
// not cleared after reset, so the first two rows of the first frame must
// be sent before any result depends on them (which raster order guarantees).
module median_filter_3x3_top (
  input logic       clk,
  input logic       rst_n,
  mf3_in_if.sink    in_if,
  mf3_out_if.source out_if,
  mf3_cfg_if.sink   cfg_if
);
  import mf3_pkg::*;

  // Configuration.
  size_t frame_width_r;
  size_t frame_height_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= size_t'(640);
      frame_height_r <= size_t'(480);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_if.data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Position tracking.
  cnt_t col_cnt_r, row_cnt_r, col_cnt_nxt, row_cnt_nxt;
  cnt_t col_last, row_last, col_base, row_base, col, row;
  tag_t tag0;
  logic acc;
  logic [FIFO_AW:0] res_cnt_r;

  assign in_if.ready = (res_cnt_r < (FIFO_AW+1)'(FIFO_DEPTH));
  assign acc         = in_if.valid && in_if.ready;

  always_comb begin
    col_last = last_pos(frame_width_r, MAX_WIDTH);
    row_last = last_pos(frame_height_r, MAX_HEIGHT);
    col_base = in_if.frame_start ? '0 : col_cnt_r;
    row_base = in_if.frame_start ? '0 : row_cnt_r;
    col      = (col_base >= col_last) ? col_last : col_base;
    row      = (row_base >= row_last) ? row_last : row_base;
    tag0.last_col = (col == col_last);
    tag0.last_row = (row == row_last);
    tag0.emit     = (col >= cnt_t'(2)) && (row >= cnt_t'(2));
    if (tag0.last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = tag0.last_row ? '0 : row + 1'b1;
    end else begin
      col_cnt_nxt = col + 1'b1;
      row_cnt_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Line stores: A holds the row above, B the row two above.
  pix_t ls_a [MAX_WIDTH];
  pix_t ls_b [MAX_WIDTH];
  pix_t rd_a_r, rd_b_r, byp_d_r, px1_r;
  cnt_t addr1_r;
  tag_t tag1_r;
  logic v1_r, byp_r;
  pix_t up1, up2;

  // B is written in the cycle after its read, so a word that reads the same
  // column right behind (back-to-back frame starts) takes the value from
  // the pending write.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a_r    <= ls_a[col];
      rd_b_r    <= ls_b[col];
      ls_a[col] <= in_if.pixel;
    end
    if (v1_r) begin
      ls_b[addr1_r] <= rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1_r   <= in_if.pixel;
      addr1_r <= col;
      tag1_r  <= tag0;
      byp_r   <= v1_r && (addr1_r == col);
      byp_d_r <= rd_a_r;
    end
  end

  assign up1 = rd_a_r;
  assign up2 = byp_r ? byp_d_r : rd_b_r;

  // Window: a row of three column cells, newest at cell 0.
  col_t cell_in [3];
  col_t cell_q  [3];

  assign cell_in[0] = {up2, up1, px1_r};
  assign cell_in[1] = cell_q[0];
  assign cell_in[2] = cell_q[1];

  for (genvar i = 0; i < 3; i++) begin : g_cell
    mf3_cell u_cell (
      .clk    (clk),
      .en     (v1_r),
      .col_in (cell_in[i]),
      .col_q  (cell_q[i])
    );
  end

  // Median of nine from sorted columns: the median of (largest low,
  // middle of middles, smallest high).
  logic v2_r, v3_r;
  tag_t tag2_r, tag3_r;
  pix_t lo_r, mid_r, hi_r;
  result_t res;
  logic push, pop, drop;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      tag2_r <= tag1_r;
    end
    if (v2_r) begin
      tag3_r <= tag2_r;
      lo_r   <= max3(cell_q[0][0], cell_q[1][0], cell_q[2][0]);
      mid_r  <= med3(cell_q[0][1], cell_q[1][1], cell_q[2][1]);
      hi_r   <= min3(cell_q[0][2], cell_q[1][2], cell_q[2][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.median    = med3(lo_r, mid_r, hi_r);
  assign res.line_end  = tag3_r.last_col;
  assign res.frame_end = tag3_r.last_col && tag3_r.last_row;
  assign push          = v3_r && tag3_r.emit;
  assign drop          = v3_r && !tag3_r.emit;

  result_t q_data;
  logic    q_valid;

  mf3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (out_if.ready),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign pop              = q_valid && out_if.ready;
  assign out_if.valid     = q_valid;
  assign out_if.median    = q_data.median;
  assign out_if.line_end  = q_data.line_end;
  assign out_if.frame_end = q_data.frame_end;

  // Queue slots reserved by every word in flight, so the queue never overflows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_r + (FIFO_AW+1)'(acc) - (FIFO_AW+1)'(pop)
                   - (FIFO_AW+1)'(drop);
    end
  end

endmodule

// File: sv/mf3_checker.sv
module mf3_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input mf3_pkg::pix_t out_median,
  input logic          out_line_end,
  input logic          out_frame_end
);
  import mf3_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_median))
    else $error("result median changed while stalled");

  a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_line_end)
    else $error("frame end without line end");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_median    (out_if.median),
  .out_line_end  (out_if.line_end),
  .out_frame_end (out_if.frame_end)
);

// File: tb/sv/median_checker.sv
`timescale 1ns / 100ps

module median_checker
  import mf3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mf3_in_if    pix_mon,
  mf3_out_if   med_mon,
  mf3_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  size_t       width_reg;
  size_t       height_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  pix_t        prev_row  [MAX_WIDTH];
  pix_t        prev_row2 [MAX_WIDTH];
  pix_t        win_regs  [9];
  result_t     median_fifo [$];

  function automatic int unsigned clamp_dim(size_t v, int unsigned hi);
    if (v < 3) begin
      return 3;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic pix_t middle_of_nine();
    pix_t sorted [9];
    pix_t v;
    int   j;
    sorted = win_regs;
    for (int i = 1; i < 9; i++) begin
      v = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > v) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = v;
    end
    return sorted[4];
  endfunction

  function automatic void take_pixel(pix_t px, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic        last_c;
    logic        last_r;
    pix_t        above1;
    pix_t        above2;
    result_t     res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // Counters left beyond a shrunken size land on the last position.
    c = (col_pos >= w - 1) ? w - 1 : col_pos;
    r = (row_pos >= h - 1) ? h - 1 : row_pos;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    above1 = prev_row[c];
    above2 = prev_row2[c];
    for (int k = 0; k < 3; k++) begin
      win_regs[k * 3]     = win_regs[k * 3 + 1];
      win_regs[k * 3 + 1] = win_regs[k * 3 + 2];
    end
    win_regs[2] = above2;
    win_regs[5] = above1;
    win_regs[8] = px;
    prev_row2[c] = above1;
    prev_row[c]  = px;
    if (c >= 2 && r >= 2) begin
      res.median    = middle_of_nine();
      res.line_end  = last_c;
      res.frame_end = last_c && last_r;
      median_fifo.push_back(res);
    end
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      width_reg  = size_t'(640);
      height_reg = size_t'(480);
      col_pos    = 0;
      row_pos    = 0;
      foreach (win_regs[k]) begin
        win_regs[k] = '0;
      end
      median_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_FRAME_WIDTH) begin
          width_reg = cfg_mon.data;
        end else begin
          height_reg = cfg_mon.data;
        end
      end
      if (pix_mon.valid && pix_mon.ready) begin
        take_pixel(pix_mon.pixel, pix_mon.frame_start);
      end
      if (med_mon.valid && med_mon.ready) begin
        got.median    = med_mon.median;
        got.line_end  = med_mon.line_end;
        got.frame_end = med_mon.frame_end;
        if (median_fifo.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected median word %0d (line_end %b frame_end %b)",
                     got.median, got.line_end, got.frame_end);
          end
          fail_count++;
        end else begin
          want = median_fifo.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("median word wrong: expected %0d/%b/%b, got %0d/%b/%b",
                       want.median, want.line_end, want.frame_end,
                       got.median, got.line_end, got.frame_end);
            end
            fail_count++;
          end
        end
      end
    end
    pending = median_fifo.size();
  end

endmodule

// File: tb/sv/median_filter_3x3_top_test.sv
`timescale 1ns / 100ps

module median_filter_3x3_top_test;
  import mf3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;
  localparam int RANDOM_ITEMS = 170;
  localparam int LONG_HOLD   = 300;

  typedef enum {PX_ANY, PX_EXTREME, PX_CLUSTER} px_style_t;
  typedef enum {FR_CLEAN, FR_RESTART, FR_RESIZE, FR_NOISE} frame_kind_t;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic        tx_idle = 1'b0;
  logic        rx_idle = 1'b0;
  logic        restart_due = 1'b0;
  int          holds_asked = 0;
  int          holds_taken = 0;
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;

  mf3_in_if  in_if ();
  mf3_out_if out_if ();
  mf3_cfg_if cfg_if ();

  median_filter_3x3_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  median_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_mon    (in_if),
    .med_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random ready bursts, plus one long hold on request.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_asked != holds_taken) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_taken++;
      end else if (rx_idle && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic int unsigned dim_used(int unsigned v, int unsigned hi);
    if (v < 3) begin
      return 3;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic pix_t pick_pixel(px_style_t style);
    case (style)
      PX_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       return pix_t'(0);
          1:       return pix_t'(255);
          default: return pix_t'($urandom_range(0, 255));
        endcase
      end
      PX_CLUSTER: return pix_t'($urandom_range(100, 103));
      default:    return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input pix_t px, input logic fs);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel       <= px;
    in_if.frame_start <= fs | restart_due;
    restart_due = 1'b0;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic stream_pixels(input int n);
    for (int p = 0; p < n; p++) begin
      push_pixel(pix_t'($urandom_range(0, 255)), p == 0);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Border pixels give no result but may still be in the pipeline.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    int unsigned w_used;
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_FRAME_WIDTH;
    cfg_if.data  <= size_t'(w);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.index <= REG_FRAME_HEIGHT;
    cfg_if.data  <= size_t'(h);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    // A wider row would read line store columns never written, so the
    // next word must restart the frame.
    w_used = dim_used(w, MAX_WIDTH);
    if (w_used > cur_w) begin
      restart_due = 1'b1;
    end
    cur_w = w_used;
    cur_h = dim_used(h, MAX_HEIGHT);
  endtask

  initial begin
    pix_t        spread_px [9];
    int          random_items;
    int          n;
    int          cut;
    int          pick;
    logic        fs;
    frame_kind_t kind;
    px_style_t   style;
    int unsigned nw;
    int unsigned nh;

    spread_px = '{pix_t'(255), pix_t'(0), pix_t'(17), pix_t'(200), pix_t'(128),
                  pix_t'(1), pix_t'(254), pix_t'(99), pix_t'(60)};
    random_items = 0;
    in_if.valid       <= 1'b0;
    in_if.pixel       <= '0;
    in_if.frame_start <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_FRAME_WIDTH;
    cfg_if.data       <= '0;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A few words at the sizes left by reset; no result is due yet.
    stream_pixels(16);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      push_pixel(spread_px[i], i == 0);
    end
    // Second frame follows the wrap of the counters, with no frame start.
    for (int i = 0; i < 9; i++) begin
      push_pixel((i < 4) ? pix_t'(0) : pix_t'(255), 1'b0);
    end
    // Frame start in the middle of a frame.
    stream_pixels(4);
    stream_pixels(9);

    // Width shrunk and height raised past its limit in the middle of a frame.
    set_size(5, 4);
    stream_pixels(8);
    set_size(0, 8191);
    for (int i = 0; i < 10; i++) begin
      push_pixel(pick_pixel(PX_EXTREME), 1'b0);
    end

    // Largest and clamped sizes without idling; the widest rows are only begun.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_size(4096, 0);
    stream_pixels(24);
    set_size(0, 8191);
    stream_pixels(3 * 8);
    set_size(8191, 3);
    stream_pixels(24);
    set_size(3, 4096);
    stream_pixels(3 * 8);

    // The result side holds off while words keep coming, filling the block.
    rx_idle = 1'b1;
    set_size(10, 10);
    holds_asked++;
    stream_pixels(cur_w * cur_h);
    drain();

    while (random_items < RANDOM_ITEMS) begin
      // The last 100 items are sent without idling, but a random frame can
      // reach 16 x 8 words, so a frame begun earlier may still idle.
      if (random_items >= RANDOM_ITEMS - 100) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        nw = (pick == 0) ? $urandom_range(0, 2) :
             (pick == 1) ? $urandom_range(9, 16) : $urandom_range(3, 8);
        nh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        set_size(nw, nh);
      end
      pick = $urandom_range(0, 9);
      kind = (pick == 0) ? FR_RESTART : (pick == 1) ? FR_RESIZE :
             (pick == 2) ? FR_NOISE : FR_CLEAN;
      style = px_style_t'($urandom_range(0, 2));
      n = cur_w * cur_h;
      cut = $urandom_range(1, n - 1);
      for (int p = 0; p < n; p++) begin
        fs = (p == 0) && ($urandom_range(0, 5) != 0);
        if (kind == FR_RESTART && p == cut) begin
          fs = 1'b1;
        end
        if (kind == FR_RESIZE && p == cut) begin
          // Only narrower rows are safe in the middle of a frame.
          set_size($urandom_range(0, cur_w), $urandom_range(0, 8));
        end
        if (kind == FR_NOISE && $urandom_range(0, 19) == 0) begin
          fs = 1'b1;
        end
        push_pixel(pick_pixel(style), fs);
        random_items++;
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
